// File: hw/rtl/ssac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssac_pkg
// Shared widths, register indexes, reset values and the blend divider for the
// scaled sprite alpha compositor.
// ----------------------------------------------------------------------------
package ssac_pkg;

    localparam int PIX_W       = 10;
    localparam int CH_W        = 8;
    localparam int LOAD_ADDR_W = 19;
    localparam int TEXEL_W     = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int MIX_W       = 16;

    // Item function codes.
    localparam logic FUNC_LOAD      = 1'b0;
    localparam logic FUNC_COMPOSITE = 1'b1;

    // Texels with alpha below this pass the background through.
    localparam logic [CH_W-1:0] ALPHA_MIN = 8'd10;
    localparam logic [CH_W-1:0] ALPHA_MAX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPRITE_X   = 3'd0,
        CFG_SPRITE_Y   = 3'd1,
        CFG_POSE_INDEX = 3'd2,
        CFG_MIRROR     = 3'd3,
        CFG_FB_WIDTH   = 3'd4,
        CFG_FB_HEIGHT  = 3'd5
    } cfg_reg_t;

    localparam logic [PIX_W-1:0] RST_SPRITE_X  = 10'd120;
    localparam logic [PIX_W-1:0] RST_SPRITE_Y  = 10'd112;
    localparam logic [2:0]       RST_POSE      = 3'd0;
    localparam logic             RST_MIRROR    = 1'b0;
    localparam logic [PIX_W-1:0] RST_FB_WIDTH  = 10'd240;
    localparam logic [PIX_W-1:0] RST_FB_HEIGHT = 10'd160;

    // Exact x / 255 for any x up to 255 * 255.
    function automatic logic [CH_W-1:0] div255(input logic [MIX_W-1:0] x);
        logic [MIX_W:0] t;
        t = {1'b0, x} + {9'b0, x[MIX_W-1:8]} + 17'd1;
        return t[MIX_W-1:8];
    endfunction

endpackage

// File: hw/rtl/scaled_sprite_alpha_compositor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_sprite_alpha_compositor
// Sprite sheet store with nearest-neighbor scaled sampling and alpha blending
// of the sampled texel over a streamed framebuffer pixel.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | input     | in_valid / in_ready  | func, load_addr, load_texel,
//          |           |                      | pix_x, pix_y, bg_red/green/blue
//  out     | output    | out_valid / out_ready| out_red/green/blue, covered
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
//  One item per cycle is accepted while in_ready is high; the four-stage
//  pipeline (decode, store access, multiply, divide) has one store port used
//  once per item. A composite beat passes through each stage in turn to the
//  output; a load beat writes the store as it leaves decode and yields no result.
//  Reset restores the registers and empties the pipeline; the store is not
//  cleared. Each stage holds only while the one after it is full and stalled.
// ----------------------------------------------------------------------------
module scaled_sprite_alpha_compositor #(
    parameter int FRAME_SIDE  = 256,
    parameter int FRAME_COUNT = 8,
    parameter int TARGET_W    = 40,
    parameter int TARGET_H    = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic [ssac_pkg::LOAD_ADDR_W-1:0]    load_addr,
    input  logic [ssac_pkg::TEXEL_W-1:0]        load_texel,
    input  logic [ssac_pkg::PIX_W-1:0]          pix_x,
    input  logic [ssac_pkg::PIX_W-1:0]          pix_y,
    input  logic [ssac_pkg::CH_W-1:0]           bg_red,
    input  logic [ssac_pkg::CH_W-1:0]           bg_green,
    input  logic [ssac_pkg::CH_W-1:0]           bg_blue,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ssac_pkg::CH_W-1:0]           out_red,
    output logic [ssac_pkg::CH_W-1:0]           out_green,
    output logic [ssac_pkg::CH_W-1:0]           out_blue,
    output logic                                covered,

    input  logic                                cfg_we,
    input  logic [ssac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssac_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SHEET_W     = FRAME_SIDE * FRAME_COUNT;
    localparam int STORE_DEPTH = SHEET_W * FRAME_SIDE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CMP_W       = ((ADDR_W > ssac_pkg::LOAD_ADDR_W) ? ADDR_W
                                  : ssac_pkg::LOAD_ADDR_W) + 1;
    localparam int DXW         = (TARGET_W > 1) ? $clog2(TARGET_W) : 1;
    localparam int DYW         = (TARGET_H > 1) ? $clog2(TARGET_H) : 1;
    localparam int FRW         = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int D_W         = ssac_pkg::PIX_W + 2;
    localparam int CH_W        = ssac_pkg::CH_W;
    localparam int MIX_W       = ssac_pkg::MIX_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ssac_pkg::PIX_W-1:0] sprite_x_reg;
    logic [ssac_pkg::PIX_W-1:0] sprite_y_reg;
    logic [2:0]                 pose_reg;
    logic                       mirror_reg;
    logic [ssac_pkg::PIX_W-1:0] fb_width_reg;
    logic [ssac_pkg::PIX_W-1:0] fb_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_x_reg  <= ssac_pkg::RST_SPRITE_X;
            sprite_y_reg  <= ssac_pkg::RST_SPRITE_Y;
            pose_reg      <= ssac_pkg::RST_POSE;
            mirror_reg    <= ssac_pkg::RST_MIRROR;
            fb_width_reg  <= ssac_pkg::RST_FB_WIDTH;
            fb_height_reg <= ssac_pkg::RST_FB_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (ssac_pkg::cfg_reg_t'(cfg_index))
                ssac_pkg::CFG_SPRITE_X:   sprite_x_reg  <= cfg_data;
                ssac_pkg::CFG_SPRITE_Y:   sprite_y_reg  <= cfg_data;
                ssac_pkg::CFG_POSE_INDEX: pose_reg      <= cfg_data[2:0];
                ssac_pkg::CFG_MIRROR:     mirror_reg    <= cfg_data[0];
                ssac_pkg::CFG_FB_WIDTH:   fb_width_reg  <= cfg_data;
                ssac_pkg::CFG_FB_HEIGHT:  fb_height_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Constant sampling tables: row base, column and frame offset.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] row_lut [TARGET_H];
    logic [ADDR_W-1:0] col_lut [TARGET_W];
    logic [ADDR_W-1:0] frame_lut [FRAME_COUNT];

    for (genvar i = 0; i < TARGET_H; i++)
    begin : g_row
        assign row_lut[i] = ADDR_W'(((i * FRAME_SIDE) / TARGET_H) * SHEET_W);
    end
    for (genvar i = 0; i < TARGET_W; i++)
    begin : g_col
        assign col_lut[i] = ADDR_W'((i * FRAME_SIDE) / TARGET_W);
    end
    for (genvar i = 0; i < FRAME_COUNT; i++)
    begin : g_frame
        assign frame_lut[i] = ADDR_W'(i * FRAME_SIDE);
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic p_valid_reg, p_valid_next;
    logic m_valid_reg, m_valid_next;
    logic b_valid_reg, b_valid_next;
    logic out_valid_reg, out_valid_next;
    logic o_en, b_en, m_en, p_en;
    logic in_accept;

    assign o_en      = !out_valid_reg || out_ready;
    assign b_en      = !b_valid_reg || o_en;
    assign m_en      = !m_valid_reg || b_en;
    assign p_en      = !p_valid_reg || m_en;
    assign in_ready  = p_en;
    assign in_accept = in_valid && p_en;

    // ------------------------------------------------------------------
    // Decode: box test, mirrored column and frame select.
    // ------------------------------------------------------------------
    logic [D_W-1:0]  dx_raw, dy_raw;
    logic            in_box;
    logic [DXW-1:0]  sdx;
    logic [FRW-1:0]  frame_sel;

    // Both offsets are kept modulo 2^D_W, so a negative one compares as large.
    assign dx_raw = {2'b00, pix_x} - {2'b00, sprite_x_reg} + D_W'(TARGET_W / 2);
    assign dy_raw = {2'b00, pix_y} - {2'b00, sprite_y_reg} + D_W'(TARGET_H);

    assign in_box = (dx_raw < D_W'(TARGET_W)) && (dy_raw < D_W'(TARGET_H)) &&
                    (pix_x < fb_width_reg) && (pix_y < fb_height_reg);

    always_comb
    begin
        if (!in_box)
            sdx = '0;
        else if (mirror_reg)
            sdx = DXW'(TARGET_W - 1) - dx_raw[DXW-1:0];
        else
            sdx = dx_raw[DXW-1:0];
    end

    assign frame_sel = (32'(pose_reg) < 32'(FRAME_COUNT)) ? FRW'(pose_reg) : '0;

    logic                              p_func_reg;
    logic [ssac_pkg::LOAD_ADDR_W-1:0]  p_addr_reg;
    logic [ssac_pkg::TEXEL_W-1:0]      p_texel_reg;
    logic                              p_inside_reg;
    logic [DYW-1:0]                    p_dy_reg;
    logic [DXW-1:0]                    p_sdx_reg;
    logic [FRW-1:0]                    p_frame_reg;
    logic [CH_W-1:0]                   p_bg_r_reg, p_bg_g_reg, p_bg_b_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p_func_reg   <= func;
            p_addr_reg   <= load_addr;
            p_texel_reg  <= load_texel;
            p_inside_reg <= in_box;
            p_dy_reg     <= in_box ? dy_raw[DYW-1:0] : '0;
            p_sdx_reg    <= sdx;
            p_frame_reg  <= frame_sel;
            p_bg_r_reg   <= bg_red;
            p_bg_g_reg   <= bg_green;
            p_bg_b_reg   <= bg_blue;
        end
    end

    // ------------------------------------------------------------------
    // Store access. Loads and reads use the port in the same stage, so
    // accesses land in beat order and no forwarding is needed.
    // ------------------------------------------------------------------
    logic [ssac_pkg::TEXEL_W-1:0] store_mem [STORE_DEPTH];
    logic [ssac_pkg::TEXEL_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]            rd_addr, wr_addr;
    logic                         load_in_range;
    logic                         mem_we, mem_re;

    assign rd_addr       = row_lut[p_dy_reg] + frame_lut[p_frame_reg] + col_lut[p_sdx_reg];
    assign wr_addr       = ADDR_W'(p_addr_reg);
    assign load_in_range = CMP_W'(p_addr_reg) < CMP_W'(STORE_DEPTH);
    assign mem_we        = p_valid_reg && m_en && (p_func_reg == ssac_pkg::FUNC_LOAD) &&
                           load_in_range;
    assign mem_re        = p_valid_reg && m_en && (p_func_reg == ssac_pkg::FUNC_COMPOSITE) &&
                           p_inside_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[wr_addr] <= p_texel_reg;
        if (mem_re)
            rd_data_reg <= store_mem[rd_addr];
    end

    logic            m_inside_reg;
    logic [CH_W-1:0] m_bg_r_reg, m_bg_g_reg, m_bg_b_reg;

    always_ff @(posedge clk)
    begin
        if (p_valid_reg && m_en)
        begin
            m_inside_reg <= p_inside_reg;
            m_bg_r_reg   <= p_bg_r_reg;
            m_bg_g_reg   <= p_bg_g_reg;
            m_bg_b_reg   <= p_bg_b_reg;
        end
    end

    // ------------------------------------------------------------------
    // Blend products.
    // ------------------------------------------------------------------
    logic [CH_W-1:0]  alpha, inv_alpha;
    logic             hit;
    logic [MIX_W-1:0] mix_r, mix_g, mix_b;

    assign alpha     = rd_data_reg[31:24];
    assign inv_alpha = ssac_pkg::ALPHA_MAX - alpha;
    assign hit       = m_inside_reg && (alpha >= ssac_pkg::ALPHA_MIN);

    assign mix_r = {8'd0, rd_data_reg[7:0]}   * {8'd0, alpha} +
                   {8'd0, m_bg_r_reg} * {8'd0, inv_alpha};
    assign mix_g = {8'd0, rd_data_reg[15:8]}  * {8'd0, alpha} +
                   {8'd0, m_bg_g_reg} * {8'd0, inv_alpha};
    assign mix_b = {8'd0, rd_data_reg[23:16]} * {8'd0, alpha} +
                   {8'd0, m_bg_b_reg} * {8'd0, inv_alpha};

    logic             b_hit_reg;
    logic [MIX_W-1:0] b_mix_r_reg, b_mix_g_reg, b_mix_b_reg;
    logic [CH_W-1:0]  b_bg_r_reg, b_bg_g_reg, b_bg_b_reg;

    always_ff @(posedge clk)
    begin
        if (m_valid_reg && b_en)
        begin
            b_hit_reg   <= hit;
            b_mix_r_reg <= mix_r;
            b_mix_g_reg <= mix_g;
            b_mix_b_reg <= mix_b;
            b_bg_r_reg  <= m_bg_r_reg;
            b_bg_g_reg  <= m_bg_g_reg;
            b_bg_b_reg  <= m_bg_b_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divide by 255 and output register.
    // ------------------------------------------------------------------
    logic [CH_W-1:0] out_red_reg, out_green_reg, out_blue_reg;
    logic            covered_reg;

    always_ff @(posedge clk)
    begin
        if (b_valid_reg && o_en)
        begin
            out_red_reg   <= b_hit_reg ? ssac_pkg::div255(b_mix_r_reg) : b_bg_r_reg;
            out_green_reg <= b_hit_reg ? ssac_pkg::div255(b_mix_g_reg) : b_bg_g_reg;
            out_blue_reg  <= b_hit_reg ? ssac_pkg::div255(b_mix_b_reg) : b_bg_b_reg;
            covered_reg   <= b_hit_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign covered   = covered_reg;

    // ------------------------------------------------------------------
    // Stage valid flags. Load beats leave the pipeline after the store stage.
    // ------------------------------------------------------------------
    always_comb
    begin
        p_valid_next   = p_en ? in_valid : p_valid_reg;
        m_valid_next   = m_en ? (p_valid_reg && (p_func_reg == ssac_pkg::FUNC_COMPOSITE))
                              : m_valid_reg;
        b_valid_next   = b_en ? m_valid_reg : b_valid_reg;
        out_valid_next = o_en ? b_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg   <= p_valid_next;
            m_valid_reg   <= m_valid_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The single store port never sees a write and a read together.
    assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
        else $error("store written and read in the same cycle");

    // Input stalls only when every stage is full and the output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (p_valid_reg && m_valid_reg && b_valid_reg && out_valid_reg &&
                       !out_ready))
        else $error("input stalled with a free stage in the pipeline");

    // A stalled multiply stage keeps its beat and its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !o_en) |=> (b_valid_reg && $stable(b_hit_reg) &&
                                    $stable(b_mix_r_reg)))
        else $error("multiply stage lost its beat during a stall");

endmodule

// File: test/tb_scaled_sprite_alpha_compositor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scaled_sprite_alpha_compositor
// Self-checking testbench for the scaled sprite alpha compositor. A local
// predictor keeps its own copy of the sprite sheet and the registers, works
// out the expected pixel for every accepted composite beat, and a monitor
// compares each output beat against the oldest prediction. Stimulus covers
// box edges, alpha threshold, mirror and pose, framebuffer clipping, a store
// write followed at once by a read, long output back-pressure, and random
// beats over several register settings.
// ----------------------------------------------------------------------------
module tb_scaled_sprite_alpha_compositor;

    localparam int PIX_W          = ssac_pkg::PIX_W;
    localparam int CH_W           = ssac_pkg::CH_W;
    localparam int LOAD_ADDR_W    = ssac_pkg::LOAD_ADDR_W;
    localparam int TEXEL_W        = ssac_pkg::TEXEL_W;
    localparam int CFG_IDX_W      = ssac_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W     = ssac_pkg::CFG_DATA_W;

    localparam int FRAME_SIDE     = 256;
    localparam int FRAME_COUNT    = 8;
    localparam int TGT_W          = 40;
    localparam int TGT_H          = 48;
    localparam int SHEET_W        = FRAME_SIDE * FRAME_COUNT;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 60;
    localparam int PHASE_BEATS    = 40;
    localparam int WATCHDOG_NS    = 2_000_000;

    typedef struct {
        logic                   f;
        logic [LOAD_ADDR_W-1:0] addr;
        logic [TEXEL_W-1:0]     texel;
        logic [PIX_W-1:0]       px;
        logic [PIX_W-1:0]       py;
        logic [CH_W-1:0]        r;
        logic [CH_W-1:0]        g;
        logic [CH_W-1:0]        b;
    } beat_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            cov;
    } pixel_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   func;
    logic [LOAD_ADDR_W-1:0] load_addr;
    logic [TEXEL_W-1:0]     load_texel;
    logic [PIX_W-1:0]       pix_x;
    logic [PIX_W-1:0]       pix_y;
    logic [CH_W-1:0]        bg_red;
    logic [CH_W-1:0]        bg_green;
    logic [CH_W-1:0]        bg_blue;
    logic                   out_valid;
    logic                   out_ready;
    logic [CH_W-1:0]        out_red;
    logic [CH_W-1:0]        out_green;
    logic [CH_W-1:0]        out_blue;
    logic                   covered;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor state: register copies and the texels written so far.
    logic [PIX_W-1:0]   cur_sprite_x = ssac_pkg::RST_SPRITE_X;
    logic [PIX_W-1:0]   cur_sprite_y = ssac_pkg::RST_SPRITE_Y;
    logic [2:0]         cur_pose     = ssac_pkg::RST_POSE;
    logic               cur_mirror   = ssac_pkg::RST_MIRROR;
    logic [PIX_W-1:0]   cur_fb_w     = ssac_pkg::RST_FB_WIDTH;
    logic [PIX_W-1:0]   cur_fb_h     = ssac_pkg::RST_FB_HEIGHT;
    logic [TEXEL_W-1:0] sheet_copy [int];
    pixel_t             expected_pixels [$];

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    bit hold_req     = 1'b0;

    int mismatch_count = 0;
    int n_loads        = 0;
    int n_composites   = 0;
    int n_blended      = 0;
    int n_results      = 0;
    int n_settings     = 1;

    scaled_sprite_alpha_compositor #(
        .FRAME_SIDE  (FRAME_SIDE),
        .FRAME_COUNT (FRAME_COUNT),
        .TARGET_W    (TGT_W),
        .TARGET_H    (TGT_H)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .load_addr  (load_addr),
        .load_texel (load_texel),
        .pix_x      (pix_x),
        .pix_y      (pix_y),
        .bg_red     (bg_red),
        .bg_green   (bg_green),
        .bg_blue    (bg_blue),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .covered    (covered),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(WATCHDOG_NS);
        $display("%0t: timeout with %0d pixels outstanding", $time, expected_pixels.size());
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Returns 1 when the pixel falls in the drawn box and gives the sheet
    // address that nearest-neighbor sampling picks for it.
    function automatic bit sheet_address(input logic [PIX_W-1:0] px,
                                         input logic [PIX_W-1:0] py,
                                         output int addr);
        int min_x;
        int min_y;
        int dx;
        int dy;
        int frame;
        int sdx;
        min_x = int'(cur_sprite_x) - TGT_W / 2;
        min_y = int'(cur_sprite_y) - TGT_H;
        dx    = int'(px) - min_x;
        dy    = int'(py) - min_y;
        addr  = 0;
        if (dx < 0 || dx >= TGT_W || dy < 0 || dy >= TGT_H ||
            px >= cur_fb_w || py >= cur_fb_h)
            return 1'b0;
        frame = (int'(cur_pose) < FRAME_COUNT) ? int'(cur_pose) : 0;
        sdx   = cur_mirror ? TGT_W - 1 - dx : dx;
        addr  = (dy * FRAME_SIDE / TGT_H) * SHEET_W +
                frame * FRAME_SIDE + sdx * FRAME_SIDE / TGT_W;
        return 1'b1;
    endfunction

    function automatic logic [CH_W-1:0] mix(input int fg, input int bg, input int a);
        return CH_W'((fg * a + bg * (int'(ssac_pkg::ALPHA_MAX) - a)) /
                     int'(ssac_pkg::ALPHA_MAX));
    endfunction

    function automatic pixel_t composite_pixel(input beat_t b);
        pixel_t             p;
        int                 addr;
        logic [TEXEL_W-1:0] t;
        int                 a;
        p.red   = b.r;
        p.green = b.g;
        p.blue  = b.b;
        p.cov   = 1'b0;
        if (sheet_address(b.px, b.py, addr))
        begin
            t = sheet_copy[addr];
            a = int'(t[31:24]);
            if (a >= int'(ssac_pkg::ALPHA_MIN))
            begin
                p.red   = mix(int'(t[7:0]), int'(b.r), a);
                p.green = mix(int'(t[15:8]), int'(b.g), a);
                p.blue  = mix(int'(t[23:16]), int'(b.b), a);
                p.cov   = 1'b1;
            end
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic beat_t rand_beat();
        beat_t b;
        b.f     = 1'($urandom);
        b.addr  = LOAD_ADDR_W'($urandom);
        b.texel = $urandom;
        b.px    = PIX_W'($urandom);
        b.py    = PIX_W'($urandom);
        b.r     = CH_W'($urandom);
        b.g     = CH_W'($urandom);
        b.b     = CH_W'($urandom);
        return b;
    endfunction

    // Alpha is biased toward the skip threshold and full opacity.
    function automatic logic [TEXEL_W-1:0] rand_texel();
        logic [7:0] alpha;
        case ($urandom_range(0, 3))
            0:       alpha = 8'($urandom_range(0, 9));
            1:       alpha = ssac_pkg::ALPHA_MAX;
            2:       alpha = 8'($urandom_range(9, 11));
            default: alpha = 8'($urandom_range(0, 255));
        endcase
        return {alpha, 24'($urandom)};
    endfunction

    // A composite beat in or just around the current drawn box.
    function automatic beat_t near_box_beat();
        beat_t b;
        b    = rand_beat();
        b.f  = ssac_pkg::FUNC_COMPOSITE;
        b.px = PIX_W'(int'(cur_sprite_x) - TGT_W / 2 - 2 + int'($urandom_range(0, TGT_W + 3)));
        b.py = PIX_W'(int'(cur_sprite_y) - TGT_H - 2 + int'($urandom_range(0, TGT_H + 3)));
        return b;
    endfunction

    task automatic send_beat(input beat_t b);
        pixel_t p;
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= b.f;
        load_addr  <= b.addr;
        load_texel <= b.texel;
        pix_x      <= b.px;
        pix_y      <= b.py;
        bg_red     <= b.r;
        bg_green   <= b.g;
        bg_blue    <= b.b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (b.f == ssac_pkg::FUNC_LOAD)
        begin
            sheet_copy[int'(b.addr)] = b.texel;
            n_loads++;
        end
        else
        begin
            p = composite_pixel(b);
            expected_pixels.push_back(p);
            n_composites++;
            if (p.cov)
                n_blended++;
        end
    endtask

    task automatic send_load(input int addr, input logic [TEXEL_W-1:0] texel);
        beat_t b;
        b       = rand_beat();
        b.f     = ssac_pkg::FUNC_LOAD;
        b.addr  = LOAD_ADDR_W'(addr);
        b.texel = texel;
        send_beat(b);
    endtask

    // Any composite that samples the sheet is preceded by a load of that
    // texel when it was never written; sometimes it is rewritten anyway.
    task automatic send_pixel(input beat_t b);
        int addr;
        if (sheet_address(b.px, b.py, addr) &&
            (!sheet_copy.exists(addr) || $urandom_range(0, 3) == 0))
            send_load(addr, rand_texel());
        send_beat(b);
    endtask

    task automatic paint_pixel(input int px, input int py, input logic [TEXEL_W-1:0] texel,
                               input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                               input logic [CH_W-1:0] bl);
        beat_t b;
        int    addr;
        b    = rand_beat();
        b.f  = ssac_pkg::FUNC_COMPOSITE;
        b.px = PIX_W'(px);
        b.py = PIX_W'(py);
        b.r  = r;
        b.g  = g;
        b.b  = bl;
        if (sheet_address(b.px, b.py, addr))
            send_load(addr, texel);
        send_beat(b);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        // Load beats give no result and may still be in flight.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input ssac_pkg::cfg_reg_t idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input logic [PIX_W-1:0] sx, input logic [PIX_W-1:0] sy,
                             input logic [2:0] pose, input logic flip,
                             input logic [PIX_W-1:0] fw, input logic [PIX_W-1:0] fh);
        drain_results();
        write_reg(ssac_pkg::CFG_SPRITE_X, sx);
        write_reg(ssac_pkg::CFG_SPRITE_Y, sy);
        write_reg(ssac_pkg::CFG_POSE_INDEX, CFG_DATA_W'(pose));
        write_reg(ssac_pkg::CFG_MIRROR, CFG_DATA_W'(flip));
        write_reg(ssac_pkg::CFG_FB_WIDTH, fw);
        write_reg(ssac_pkg::CFG_FB_HEIGHT, fh);
        cur_sprite_x = sx;
        cur_sprite_y = sy;
        cur_pose     = pose;
        cur_mirror   = flip;
        cur_fb_w     = fw;
        cur_fb_h     = fh;
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: box spans columns 100..139 and rows 64..111.
    task automatic test_reset_box_edges();
        paint_pixel(100, 64, 32'hFF_00_FF_00, 8'h00, 8'h00, 8'h00);
        paint_pixel(139, 111, 32'h0A_FF_00_FF, 8'hFF, 8'hFF, 8'hFF);
        paint_pixel(100, 111, 32'h09_FF_FF_FF, 8'h12, 8'h34, 8'h56);
        paint_pixel(139, 64, 32'h00_FF_FF_FF, 8'hFF, 8'h00, 8'hFF);
        paint_pixel(99, 64, 32'hFF_FF_FF_FF, 8'h55, 8'hAA, 8'h55);
        paint_pixel(140, 111, 32'hFF_FF_FF_FF, 8'hAA, 8'h55, 8'hAA);
        paint_pixel(100, 63, 32'hFF_FF_FF_FF, 8'h00, 8'h00, 8'h00);
        paint_pixel(139, 112, 32'hFF_FF_FF_FF, 8'hFF, 8'hFF, 8'hFF);
    endtask

    task automatic test_mirror_last_pose();
        configure(10'd120, 10'd112, 3'd7, 1'b1, 10'd240, 10'd160);
        paint_pixel(100, 64, 32'h80_C0_40_20, 8'h10, 8'hF0, 8'h80);
        paint_pixel(139, 111, 32'hFF_01_02_03, 8'hFF, 8'h00, 8'hFF);
    endtask

    // Box hangs off the top-left corner and is clipped by a tiny framebuffer.
    task automatic test_framebuffer_clip();
        configure(10'd10, 10'd40, 3'd0, 1'b0, 10'd5, 10'd20);
        paint_pixel(4, 19, 32'hC8_11_22_33, 8'hEE, 8'hDD, 8'hCC);
        paint_pixel(5, 19, 32'hFF_FF_FF_FF, 8'h01, 8'h02, 8'h03);
        paint_pixel(4, 20, 32'hFF_FF_FF_FF, 8'h04, 8'h05, 8'h06);
        paint_pixel(0, 0, 32'hC8_44_55_66, 8'h77, 8'h88, 8'h99);
        paint_pixel(1023, 1023, 32'hFF_FF_FF_FF, 8'hFF, 8'hFF, 8'hFF);
    endtask

    // A store write directly followed by a read of the same texel.
    task automatic test_load_then_read();
        beat_t b;
        int    addr;
        src_idle_en = 1'b0;
        b    = rand_beat();
        b.f  = ssac_pkg::FUNC_COMPOSITE;
        b.px = 10'd2;
        b.py = 10'd10;
        void'(sheet_address(b.px, b.py, addr));
        send_load(addr, 32'hFF_AB_CD_EF);
        send_beat(b);
        send_load(addr, 32'h40_12_34_56);
        send_beat(b);
        src_idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        configure(10'd120, 10'd112, 3'd1, 1'b0, 10'd240, 10'd160);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        hold_req     = 1'b1;
        repeat (30) send_pixel(near_box_beat());
        // Pause the sender until every pending pixel has come out.
        drain_results();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        repeat (10) send_pixel(near_box_beat());
    endtask

    task automatic test_random_phases();
        beat_t b;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: configure(10'd120, 10'd112, 3'd2, 1'b1, 10'd240, 10'd160);
                1: configure(10'd0, 10'd48, 3'd7, 1'b1, 10'd1023, 10'd1023);
                2: configure(10'd1023, 10'd1023, 3'd3, 1'b0, 10'd1023, 10'd1023);
                3: configure(10'd500, 10'd300, 3'd5, 1'b1, 10'd510, 10'd280);
                4: configure(10'd10, 10'd0, 3'd0, 1'b0, 10'd1, 10'd1);
                default: configure(PIX_W'($urandom), PIX_W'($urandom), 3'($urandom),
                                   1'($urandom), PIX_W'($urandom_range(1, 1023)),
                                   PIX_W'($urandom_range(1, 1023)));
            endcase
            // The last phase runs with both sides at full rate.
            src_idle_en  = (ph != 7);
            sink_idle_en = (ph != 7);
            repeat (PHASE_BEATS)
            begin
                b = rand_beat();
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        b.f = ssac_pkg::FUNC_LOAD;
                        send_beat(b);
                    end
                    2:
                    begin
                        b.f = ssac_pkg::FUNC_COMPOSITE;
                        send_pixel(b);
                    end
                    default: send_pixel(near_box_beat());
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: ready pattern and result monitor
    // ------------------------------------------------------------------

    initial
    begin : sink_ctrl
        int gap;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (sink_idle_en && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                gap = $urandom_range(1, 5);
                repeat (gap) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: output beat with no pixel pending, actual %0d %0d %0d %0d",
                         $time, out_red, out_green, out_blue, covered);
                mismatch_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("out_red", want.red, out_red);
                check_field("out_green", want.green, out_green);
                check_field("out_blue", want.blue, out_blue);
                check_field("covered", want.cov, covered);
                n_results++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        func       = ssac_pkg::FUNC_LOAD;
        load_addr  = '0;
        load_texel = '0;
        pix_x      = '0;
        pix_y      = '0;
        bg_red     = '0;
        bg_green   = '0;
        bg_blue    = '0;
        cfg_we     = 1'b0;
        cfg_index  = ssac_pkg::CFG_SPRITE_X;
        cfg_data   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_box_edges();
        test_mirror_last_pose();
        test_framebuffer_clip();
        test_load_then_read();
        test_backpressure();
        test_random_phases();

        drain_results();
        $display("Run covered %0d texel loads and %0d composite pixels (%0d blended).",
                 n_loads, n_composites, n_blended);
        $display("%0d pixels checked across %0d register settings, %0d mismatches.",
                 n_results, n_settings, mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
